// ===== rtl/salp_pkg.sv =====
// Shared types, character codes and helpers for the sensor line parser.
`timescale 1ns / 1ps

package salp_pkg;

  // ASCII codes used by the line grammar
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;

  // Position inside the current line
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_NOVAL,
    PH_NUM,
    PH_SKIPTOK,
    PH_TRAIL,
    PH_DONE
  } phase_e;

  // What the mode character turned out to be
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ZERO,
    MODE_ONE,
    MODE_BAD
  } mode_e;

  // Ten to the power n, for sizing the digit accumulator at elaboration
  function automatic logic [63:0] pow10(int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

// ===== rtl/sensor_ascii_line_parser_core.sv =====
// Streaming parser for the gyro's ASCII output lines (top level).
`timescale 1ns / 1ps

// Takes one received byte per request on the slave side and emits one result
// request per CR LF pair on the master side. Each accepted byte updates the
// line state (phase, sign, digit accumulator, counters) in one pass whose
// deepest path is the times-ten shift-and-add on the accumulator, so the
// input accepts a byte every cycle while the result
// register is free or being drained. The result is loaded into the output
// register at the edge that accepts the LF and is offered from the next cycle
// on. While a result waits and the master side does not take it, the input
// stalls on every byte, so back-to-back lines run at full rate only while the
// master side keeps up. The value is reported as a signed decimal mantissa
// plus a count of fraction digits; more than MAX_DIGITS digits saturate the
// mantissa and raise the overflow flag.
module sensor_ascii_line_parser_core #(
  parameter int unsigned MAX_DIGITS = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [30:0] mantissa, [34:31] frac_digits, zero fill
  output logic [2:0]  m_axis_tuser_o    // [0] parse_ok, [1] data_valid, [2] overflow
);
  import salp_pkg::*;

  localparam logic [63:0] MaxMag = pow10(MAX_DIGITS) - 64'd1;
  localparam int unsigned AccW   = $clog2(MaxMag + 64'd1);
  localparam int unsigned CntW   = $clog2(MAX_DIGITS + 1);

  // line state
  phase_e            phase_q, phase_d;
  mode_e             mode_q, mode_d;
  logic              space_seen_q, space_seen_d;
  logic              negative_q, negative_d;
  logic [AccW-1:0]   accum_q, accum_d;
  logic [CntW-1:0]   digit_cnt_q, digit_cnt_d;
  logic [CntW-1:0]   frac_cnt_q, frac_cnt_d;
  logic              point_q, point_d;
  logic              prev_cr_q, prev_cr_d;
  logic              ovf_q, ovf_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              parse_ok_q, data_valid_q, ovf_out_q;
  logic signed [30:0] mantissa_q;
  logic [3:0]        frac_out_q;

  logic [7:0]        c;
  logic              in_fire, end_line;
  logic              is_space, is_eol, is_digit, num_bad, num_active;
  logic [3:0]        digit_val;
  logic [AccW-1:0]   accum_x10;
  logic [AccW-1:0]   mag;
  logic [30:0]       mant_wide;

  assign c         = s_axis_tdata_i;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign end_line  = prev_cr_q && (c == ChLf);
  assign is_space  = (c == ChSpace);
  assign is_eol    = (c == ChCr) || (c == ChLf);
  assign is_digit  = (c >= ChZero) && (c <= ChNine);
  assign digit_val = 4'(c - ChZero);
  assign num_bad   = !is_digit && !((c == ChPoint) && !point_q);

  // a token byte that feeds the numeric prefix
  assign num_active =
      ((phase_q == PH_LEAD) && space_seen_q && !is_space && !is_eol &&
       (c != ChMinus) && (c != ChPlus)) ||
      ((phase_q == PH_NUM) && !is_space && !is_eol);

  // accept while the result slot is free or being drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  // next phase and mode
  always_comb begin
    phase_d = phase_q;
    mode_d  = mode_q;
    if (end_line) begin
      phase_d = PH_LEAD;
      mode_d  = MODE_NONE;
    end else begin
      unique case (phase_q)
        PH_LEAD: begin
          if (!is_space && !is_eol) begin
            if (!space_seen_q) begin
              phase_d = PH_NOVAL;
            end else if ((c == ChMinus) || (c == ChPlus) || !num_bad) begin
              phase_d = PH_NUM;
            end else begin
              phase_d = PH_SKIPTOK;
            end
          end
        end
        PH_NUM, PH_SKIPTOK: begin
          if (is_space) begin
            phase_d = PH_TRAIL;
          end else if (is_eol) begin
            mode_d  = MODE_BAD;
            phase_d = PH_DONE;
          end else if ((phase_q == PH_NUM) && num_bad) begin
            phase_d = PH_SKIPTOK;
          end
        end
        PH_TRAIL: begin
          if (!is_space) begin
            phase_d = PH_DONE;
            if (c == ChOne) begin
              mode_d = MODE_ONE;
            end else if (c == ChZero) begin
              mode_d = MODE_ZERO;
            end else begin
              mode_d = MODE_BAD;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // accumulate sign, digits and counters
  assign accum_x10 = (accum_q << 3) + (accum_q << 1);

  always_comb begin
    space_seen_d = space_seen_q;
    negative_d   = negative_q;
    accum_d      = accum_q;
    digit_cnt_d  = digit_cnt_q;
    frac_cnt_d   = frac_cnt_q;
    point_d      = point_q;
    ovf_d        = ovf_q;
    prev_cr_d    = (c == ChCr);
    if (end_line) begin
      space_seen_d = 1'b0;
      negative_d   = 1'b0;
      accum_d      = '0;
      digit_cnt_d  = '0;
      frac_cnt_d   = '0;
      point_d      = 1'b0;
      ovf_d        = 1'b0;
      prev_cr_d    = 1'b0;
    end else begin
      if ((phase_q == PH_LEAD) && is_space) begin
        space_seen_d = 1'b1;
      end
      if ((phase_q == PH_LEAD) && space_seen_q && (c == ChMinus)) begin
        negative_d = 1'b1;
      end
      if (num_active) begin
        if (is_digit) begin
          if (digit_cnt_q >= CntW'(MAX_DIGITS)) begin
            ovf_d = 1'b1;
          end else begin
            accum_d     = accum_x10 + AccW'(digit_val);
            digit_cnt_d = digit_cnt_q + 1'b1;
            if (point_q) begin
              frac_cnt_d = frac_cnt_q + 1'b1;
            end
          end
        end else if ((c == ChPoint) && !point_q) begin
          point_d = 1'b1;
        end
      end
    end
  end

  // signed mantissa from the line state, saturated on overflow
  assign mag       = ovf_q ? MaxMag[AccW-1:0] : accum_q;
  assign mant_wide = negative_q ? (31'd0 - 31'(mag)) : 31'(mag);

  // hold the result until the master side takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && end_line) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEAD;
      mode_q       <= MODE_NONE;
      space_seen_q <= 1'b0;
      negative_q   <= 1'b0;
      accum_q      <= '0;
      digit_cnt_q  <= '0;
      frac_cnt_q   <= '0;
      point_q      <= 1'b0;
      prev_cr_q    <= 1'b0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q      <= phase_d;
        mode_q       <= mode_d;
        space_seen_q <= space_seen_d;
        negative_q   <= negative_d;
        accum_q      <= accum_d;
        digit_cnt_q  <= digit_cnt_d;
        frac_cnt_q   <= frac_cnt_d;
        point_q      <= point_d;
        prev_cr_q    <= prev_cr_d;
        ovf_q        <= ovf_d;
      end
    end
  end

  // result payload, loaded at the LF of a CR LF pair
  always_ff @(posedge clk_i) begin
    if (in_fire && end_line) begin
      parse_ok_q   <= (mode_q == MODE_ZERO) || (mode_q == MODE_ONE);
      data_valid_q <= (mode_q == MODE_ONE);
      mantissa_q   <= signed'(mant_wide);
      frac_out_q   <= 4'(frac_cnt_q);
      ovf_out_q    <= ovf_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, frac_out_q, mantissa_q};
  assign m_axis_tuser_o  = {ovf_out_q, data_valid_q, parse_ok_q};

  // digit counters stay within the kept range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_cnt_q <= CntW'(MAX_DIGITS)) && (frac_cnt_q <= digit_cnt_q))
    else $error("digit counters out of range");

  // overflow only once all digit slots are used
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (digit_cnt_q == CntW'(MAX_DIGITS)))
    else $error("overflow set with free digit slots");

  // a line end clears the line state and raises the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && end_line) |=>
      (phase_q == PH_LEAD) && !space_seen_q && !prev_cr_q && m_axis_tvalid_o)
    else $error("line state not cleared after line end");

  // the input stalls only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a pending result");

endmodule
